@@ src/key_event_detector_macros.svh @@
// ----------------------------------------------------------------------------
// key_event_detector_macros
// Assertion macros shared by the key event detector modules. Define
// ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef KEY_EVENT_DETECTOR_MACROS_SVH
`define KEY_EVENT_DETECTOR_MACROS_SVH

`ifndef ASSERT_OFF

// Check that an expression holds at every clock edge outside reset
`define KED_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a condition implies a consequence in the next cycle
`define KED_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define KED_ASSERT_ALWAYS(label, clk, rst, expr, msg)
`define KED_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

@@ src/ked_pkg.sv @@
// ----------------------------------------------------------------------------
// ked_pkg
// Shared constants, codes and control structs of the key event detector.
// ----------------------------------------------------------------------------
package ked_pkg;

   // Key count and field widths
   localparam int NUM_KEYS = 10;
   localparam int KEY_W    = 4;
   localparam int KIND_W   = 3;
   localparam int TIME_W   = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [KEY_W-1:0] LAST_KEY = KEY_W'(NUM_KEYS - 1);

   // Event codes
   localparam logic [KIND_W-1:0] EV_PRESS   = 3'd0;
   localparam logic [KIND_W-1:0] EV_RELEASE = 3'd1;
   localparam logic [KIND_W-1:0] EV_LONG    = 3'd2;
   localparam logic [KIND_W-1:0] EV_REPEAT  = 3'd3;
   localparam logic [KIND_W-1:0] EV_DOUBLE  = 3'd4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_SCANS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCAN_STEP      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT         = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DOUBLE_CLICK   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DC_ENABLE      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_HIGH    = 3'd6;

   // Sequencer states, also the phase code seen by the datapath
   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] ST_IDLE  = 3'd0;
   localparam logic [ST_W-1:0] ST_DEB   = 3'd1;
   localparam logic [ST_W-1:0] ST_REL   = 3'd2;
   localparam logic [ST_W-1:0] ST_LONG  = 3'd3;
   localparam logic [ST_W-1:0] ST_REP   = 3'd4;
   localparam logic [ST_W-1:0] ST_DCT   = 3'd5;
   localparam logic [ST_W-1:0] ST_FLUSH = 3'd6;

   typedef struct packed {
      logic [7:0]          debounce_scans;
      logic [7:0]          scan_step;
      logic [15:0]         long_press_time;
      logic [15:0]         repeat_time;
      logic [15:0]         double_click_time;
      logic [NUM_KEYS-1:0] double_click_enable;
      logic [NUM_KEYS-1:0] active_high_keys;
   } cfg_type;

   typedef struct packed {
      logic             start;
      logic             exec;
      logic             flush;
      logic [ST_W-1:0]  phase;
      logic [KEY_W-1:0] key;
   } cmd_type;

   typedef struct packed {
      logic emit_ready;
      logic rel_edge;
   } status_type;

endpackage

@@ src/ked_csr.sv @@
// ----------------------------------------------------------------------------
// ked_csr
// Configuration register file of the key event detector.
// ----------------------------------------------------------------------------
module ked_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   input  logic [ked_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ked_pkg::CSR_DATA_W-1:0] csr_data,
   output ked_pkg::cfg_type               cfg
);

   ked_pkg::cfg_type cfg_ff, cfg_in;

   // Decode the register index; unknown indexes drop the write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            ked_pkg::CSR_DEBOUNCE_SCANS: cfg_in.debounce_scans    = csr_data[7:0];
            ked_pkg::CSR_SCAN_STEP:      cfg_in.scan_step         = csr_data[7:0];
            ked_pkg::CSR_LONG_PRESS:     cfg_in.long_press_time   = csr_data;
            ked_pkg::CSR_REPEAT:         cfg_in.repeat_time       = csr_data;
            ked_pkg::CSR_DOUBLE_CLICK:   cfg_in.double_click_time = csr_data;
            ked_pkg::CSR_DC_ENABLE:
               cfg_in.double_click_enable = csr_data[ked_pkg::NUM_KEYS-1:0];
            ked_pkg::CSR_ACTIVE_HIGH:
               cfg_in.active_high_keys = csr_data[ked_pkg::NUM_KEYS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_scans      <= 8'd3;
         cfg_ff.scan_step           <= 8'd10;
         cfg_ff.long_press_time     <= 16'd1000;
         cfg_ff.repeat_time         <= 16'd200;
         cfg_ff.double_click_time   <= 16'd300;
         cfg_ff.double_click_enable <= '0;
         cfg_ff.active_high_keys    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ src/ked_ctrl.sv @@
// ----------------------------------------------------------------------------
// ked_ctrl
// Scan sequencer: walks the keys and their check phases, issuing commands
// to the datapath.
// ----------------------------------------------------------------------------
`include "key_event_detector_macros.svh"

module ked_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  ked_pkg::status_type status,
   output ked_pkg::cmd_type    cmd
);

   logic [ked_pkg::ST_W-1:0]  state_ff, state_in;
   logic [ked_pkg::KEY_W-1:0] key_ff, key_in;
   logic                      active;

   // Take a scan only while idle
   assign req_stall = (state_ff != ked_pkg::ST_IDLE);

   assign active = (state_ff == ked_pkg::ST_DEB)  || (state_ff == ked_pkg::ST_REL) ||
                   (state_ff == ked_pkg::ST_LONG) || (state_ff == ked_pkg::ST_REP) ||
                   (state_ff == ked_pkg::ST_DCT);

   // Build the command; each step waits for room in the event stage
   always_comb begin
      cmd.start = (state_ff == ked_pkg::ST_IDLE) && req_valid;
      cmd.exec  = active && status.emit_ready;
      cmd.flush = (state_ff == ked_pkg::ST_FLUSH) && status.emit_ready;
      cmd.phase = state_ff;
      cmd.key   = key_ff;
   end

   // Advance through phases and keys
   always_comb begin
      state_in = state_ff;
      key_in   = key_ff;
      unique case (state_ff)
         ked_pkg::ST_IDLE: begin
            if (cmd.start) begin
               state_in = ked_pkg::ST_DEB;
               key_in   = '0;
            end
         end
         ked_pkg::ST_DEB: begin
            if (cmd.exec) begin
               state_in = status.rel_edge ? ked_pkg::ST_REL : ked_pkg::ST_LONG;
            end
         end
         ked_pkg::ST_REL: begin
            if (cmd.exec) state_in = ked_pkg::ST_LONG;
         end
         ked_pkg::ST_LONG: begin
            if (cmd.exec) state_in = ked_pkg::ST_REP;
         end
         ked_pkg::ST_REP: begin
            if (cmd.exec) state_in = ked_pkg::ST_DCT;
         end
         ked_pkg::ST_DCT: begin
            if (cmd.exec) begin
               if (key_ff == ked_pkg::LAST_KEY) begin
                  state_in = ked_pkg::ST_FLUSH;
               end else begin
                  state_in = ked_pkg::ST_DEB;
                  key_in   = key_ff + 1'b1;
               end
            end
         end
         ked_pkg::ST_FLUSH: begin
            if (cmd.flush) state_in = ked_pkg::ST_IDLE;
         end
         default: state_in = ked_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ked_pkg::ST_IDLE;
         key_ff   <= '0;
      end else begin
         state_ff <= state_in;
         key_ff   <= key_in;
      end
   end

   `KED_ASSERT_ALWAYS(a_key_range, clock, reset, key_ff <= ked_pkg::LAST_KEY, "key index out of range")
   `KED_ASSERT_NEXT(a_start_first_key, clock, reset, cmd.start, (state_ff == ked_pkg::ST_DEB) && (key_ff == '0), "scan did not begin at key zero")
   `KED_ASSERT_NEXT(a_flush_idle, clock, reset, cmd.flush, state_ff == ked_pkg::ST_IDLE, "flush did not end the scan")

endmodule

@@ src/ked_datapath.sv @@
// ----------------------------------------------------------------------------
// ked_datapath
// Per-key state, debounce and timing checks, event hold stage and the
// result register.
// ----------------------------------------------------------------------------
`include "key_event_detector_macros.svh"

module ked_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  ked_pkg::cmd_type                  cmd,
   output ked_pkg::status_type               status,
   input  ked_pkg::cfg_type                  cfg,
   input  logic [ked_pkg::NUM_KEYS-1:0]      req_raw_levels,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output logic [ked_pkg::KEY_W-1:0]         rsp_key_index,
   output logic [ked_pkg::KIND_W-1:0]        rsp_event_kind,
   output logic                              rsp_last_event
);

   localparam int NK = ked_pkg::NUM_KEYS;
   localparam int TW = ked_pkg::TIME_W;

   // Scan time and latched levels
   logic [TW-1:0] time_now_ff, time_now_in;
   logic [NK-1:0] levels_ff, levels_in;

   // Per-key state
   logic [7:0]    debounce_count_ff [NK];
   logic [7:0]    debounce_count_in [NK];
   logic [NK-1:0] stable_ff, stable_in;
   logic [NK-1:0] long_fired_ff, long_fired_in;
   logic [NK-1:0] waiting_ff, waiting_in;
   logic [NK-1:0] second_ff, second_in;
   logic [TW-1:0] press_time_ff [NK];
   logic [TW-1:0] press_time_in [NK];
   logic [TW-1:0] repeat_stamp_ff [NK];
   logic [TW-1:0] repeat_stamp_in [NK];
   logic [TW-1:0] release_time_ff [NK];
   logic [TW-1:0] release_time_in [NK];

   // Event hold stage and result register
   logic                         hold_valid_ff, hold_valid_in;
   logic [ked_pkg::KEY_W-1:0]    hold_key_ff, hold_key_in;
   logic [ked_pkg::KIND_W-1:0]   hold_kind_ff, hold_kind_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [ked_pkg::KEY_W-1:0]    rsp_key_ff, rsp_key_in;
   logic [ked_pkg::KIND_W-1:0]   rsp_kind_ff, rsp_kind_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic [ked_pkg::KEY_W-1:0]  k;
   logic                       pressed;
   logic                       dc_on;
   logic                       disagree;
   logic                       flip;
   logic [7:0]                 cnt_inc;
   logic [TW-1:0]              ref_time;
   logic [15:0]                threshold;
   logic [TW-1:0]              elapsed;
   logic                       time_ge;
   logic                       ev_fire;
   logic [ked_pkg::KIND_W-1:0] ev_kind;
   logic                       out_free;
   logic                       push;

   assign k        = cmd.key;
   assign pressed  = ~(levels_ff[k] ^ cfg.active_high_keys[k]);
   assign dc_on    = cfg.double_click_enable[k];
   assign cnt_inc  = debounce_count_ff[k] + 8'd1;
   assign disagree = (pressed != stable_ff[k]);
   assign flip     = disagree && (cnt_inc >= cfg.debounce_scans);

   // Share one elapsed-time compare across the three timing checks
   always_comb begin
      unique case (cmd.phase)
         ked_pkg::ST_LONG: begin
            ref_time  = press_time_ff[k];
            threshold = cfg.long_press_time;
         end
         ked_pkg::ST_REP: begin
            ref_time  = repeat_stamp_ff[k];
            threshold = cfg.repeat_time;
         end
         ked_pkg::ST_DCT: begin
            ref_time  = release_time_ff[k];
            threshold = cfg.double_click_time;
         end
         default: begin
            ref_time  = press_time_ff[k];
            threshold = '0;
         end
      endcase
   end

   assign elapsed = time_now_ff - ref_time;
   assign time_ge = (elapsed >= {16'd0, threshold});

   // Update the current key for the phase in hand
   always_comb begin
      time_now_in       = time_now_ff;
      levels_in         = levels_ff;
      debounce_count_in = debounce_count_ff;
      stable_in         = stable_ff;
      long_fired_in     = long_fired_ff;
      waiting_in        = waiting_ff;
      second_in         = second_ff;
      press_time_in     = press_time_ff;
      repeat_stamp_in   = repeat_stamp_ff;
      release_time_in   = release_time_ff;
      ev_fire           = 1'b0;
      ev_kind           = ked_pkg::EV_PRESS;

      if (cmd.start) begin
         time_now_in = time_now_ff + {24'd0, cfg.scan_step};
         levels_in   = req_raw_levels;
      end

      if (cmd.exec) begin
         unique case (cmd.phase)
            ked_pkg::ST_DEB: begin
               if (!disagree) begin
                  debounce_count_in[k] = '0;
               end else if (!flip) begin
                  debounce_count_in[k] = cnt_inc;
               end else begin
                  debounce_count_in[k] = '0;
                  stable_in[k]         = pressed;
                  if (pressed) begin
                     if (waiting_ff[k]) begin
                        waiting_in[k] = 1'b0;
                        second_in[k]  = 1'b1;
                     end
                     press_time_in[k]   = time_now_ff;
                     repeat_stamp_in[k] = time_now_ff;
                     long_fired_in[k]   = 1'b0;
                  end else if (!long_fired_ff[k]) begin
                     priority if (second_ff[k]) begin
                        second_in[k] = 1'b0;
                        ev_fire      = 1'b1;
                        ev_kind      = ked_pkg::EV_DOUBLE;
                     end else if (dc_on) begin
                        release_time_in[k] = time_now_ff;
                        waiting_in[k]      = 1'b1;
                     end else begin
                        ev_fire = 1'b1;
                        ev_kind = ked_pkg::EV_PRESS;
                     end
                  end
               end
            end
            ked_pkg::ST_REL: begin
               ev_fire = 1'b1;
               ev_kind = ked_pkg::EV_RELEASE;
            end
            ked_pkg::ST_LONG: begin
               if (stable_ff[k] && !long_fired_ff[k] && time_ge) begin
                  long_fired_in[k] = 1'b1;
                  ev_fire          = 1'b1;
                  ev_kind          = ked_pkg::EV_LONG;
               end
            end
            ked_pkg::ST_REP: begin
               if (stable_ff[k] && long_fired_ff[k] && time_ge) begin
                  repeat_stamp_in[k] = time_now_ff;
                  ev_fire            = 1'b1;
                  ev_kind            = ked_pkg::EV_REPEAT;
               end
            end
            ked_pkg::ST_DCT: begin
               if (waiting_ff[k] && dc_on && time_ge) begin
                  waiting_in[k] = 1'b0;
                  ev_fire       = 1'b1;
                  ev_kind       = ked_pkg::EV_PRESS;
               end
            end
            default: ;
         endcase
      end
   end

   // Hold one event back so the last of a scan can be marked
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign push     = hold_valid_ff && (ev_fire || cmd.flush);

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_key_in   = hold_key_ff;
      hold_kind_in  = hold_kind_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_stall ? rsp_valid_ff : 1'b0;

      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_key_in   = hold_key_ff;
         rsp_kind_in  = hold_kind_ff;
         rsp_last_in  = cmd.flush;
      end

      if (ev_fire) begin
         hold_valid_in = 1'b1;
         hold_key_in   = k;
         hold_kind_in  = ev_kind;
      end else if (cmd.flush) begin
         hold_valid_in = 1'b0;
      end
   end

   always_comb begin
      status.emit_ready = !hold_valid_ff || out_free;
      status.rel_edge   = flip && !pressed;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         time_now_ff       <= '0;
         debounce_count_ff <= '{default: '0};
         stable_ff         <= '0;
         long_fired_ff     <= '0;
         waiting_ff        <= '0;
         second_ff         <= '0;
         hold_valid_ff     <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         time_now_ff       <= time_now_in;
         debounce_count_ff <= debounce_count_in;
         stable_ff         <= stable_in;
         long_fired_ff     <= long_fired_in;
         waiting_ff        <= waiting_in;
         second_ff         <= second_in;
         hold_valid_ff     <= hold_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // Payload: time stamps are always written before they are read
   always_ff @(posedge clock) begin
      levels_ff       <= levels_in;
      press_time_ff   <= press_time_in;
      repeat_stamp_ff <= repeat_stamp_in;
      release_time_ff <= release_time_in;
      hold_key_ff     <= hold_key_in;
      hold_kind_ff    <= hold_kind_in;
      rsp_key_ff      <= rsp_key_in;
      rsp_kind_ff     <= rsp_kind_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_key_index  = rsp_key_ff;
   assign rsp_event_kind = rsp_kind_ff;
   assign rsp_last_event = rsp_last_ff;

   `KED_ASSERT_ALWAYS(a_push_room, clock, reset, !push || out_free, "event pushed over a waiting result")
   `KED_ASSERT_NEXT(a_flush_empty, clock, reset, cmd.flush, !hold_valid_ff, "hold stage not empty after flush")

endmodule

@@ src/key_event_detector.sv @@
// ----------------------------------------------------------------------------
// key_event_detector
// Debounced multi-key scanner with press, release, long press, repeat and
// double click events.
// ----------------------------------------------------------------------------
// Each accepted scan advances the time counter by scan_step and then visits
// the ten keys in index order, one check phase per cycle while the event
// stage has room: debounce, release (only on a debounced release), long
// press, repeat and double-click timeout, the last three sharing one 32-bit
// elapsed-time subtract and compare. A new scan is not accepted until the
// last one has flushed, and its steps wait while the result channel stalls.
// Events leave one per transfer in key order; the last event of a scan
// carries last_event. A scan with no event produces no result. Configuration
// writes are taken in any cycle and should be made while no scan is in
// flight.
module key_event_detector (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [ked_pkg::NUM_KEYS-1:0]   req_raw_levels,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [ked_pkg::KEY_W-1:0]      rsp_key_index,
   output logic [ked_pkg::KIND_W-1:0]     rsp_event_kind,
   output logic                           rsp_last_event,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ked_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ked_pkg::CSR_DATA_W-1:0] csr_data
);

   ked_pkg::cfg_type    cfg;
   ked_pkg::cmd_type    cmd;
   ked_pkg::status_type status;

   // Registers accept a write every cycle
   assign csr_ready = 1'b1;

   ked_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ked_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ked_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .cfg            (cfg),
      .req_raw_levels (req_raw_levels),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_key_index  (rsp_key_index),
      .rsp_event_kind (rsp_event_kind),
      .rsp_last_event (rsp_last_event)
   );

endmodule
